/* hw/rtl/date_difference_hours_core_assert.svh */
// ----------------------------------------------------------------------------
// date_difference_hours_core_assert.svh
// assertion macros shared by the date difference core
// ----------------------------------------------------------------------------
`ifndef DATE_DIFFERENCE_HOURS_CORE_ASSERT_SVH
`define DATE_DIFFERENCE_HOURS_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define DDH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ddh assertion failed");

`define DDH_ASSERT_MSG(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`else

`define DDH_ASSERT(label, clk, rst_n, prop)

`define DDH_ASSERT_MSG(label, clk, rst_n, prop, msg)

`endif

`endif

/* hw/rtl/ddh_pkg.sv */
// ----------------------------------------------------------------------------
// ddh_pkg
// widths, constants and tables for the date difference core
// ----------------------------------------------------------------------------
package ddh_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int HOURS_W = 24;

    // year / 100 by reciprocal multiply, result floor or floor - 1
    localparam int RECIP_100   = 655;
    localparam int RECIP_W     = 10;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int REM0_W      = 8;
    localparam int REM_W       = 7;
    localparam int CENTURY     = 100;

    localparam int DAYS_PER_YEAR = 365;
    localparam int SEC_PER_MIN   = 60;
    localparam int MONTH_FEB     = 2;

    localparam int DBM_W  = 9;
    localparam int DIDX_W = 21;
    localparam int SUM_W  = DIDX_W + 1;
    localparam int HD_W   = HOUR_W + 1;
    localparam int MS_W   = 13;
    localparam int WIDE_W = 27;

    localparam int HOURS_MAX = (1 << (HOURS_W - 1)) - 1;
    localparam int HOURS_MIN = -(1 << (HOURS_W - 1));

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_pipe_en;

    // days before the month; out of range codes act as january or december
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
        logic [DBM_W-1:0] dbm;
        unique case (m) inside
            4'd0, 4'd1:                dbm = 9'd0;
            4'd2:                      dbm = 9'd31;
            4'd3:                      dbm = 9'd59;
            4'd4:                      dbm = 9'd90;
            4'd5:                      dbm = 9'd120;
            4'd6:                      dbm = 9'd151;
            4'd7:                      dbm = 9'd181;
            4'd8:                      dbm = 9'd212;
            4'd9:                      dbm = 9'd243;
            4'd10:                     dbm = 9'd273;
            4'd11:                     dbm = 9'd304;
            4'd12, 4'd13, 4'd14, 4'd15: dbm = 9'd334;
            default:                   dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage

/* hw/rtl/ddh_date_split.sv */
// ----------------------------------------------------------------------------
// ddh_date_split
// stages one and two: splits the year into centuries and year of century
// ----------------------------------------------------------------------------
module ddh_date_split (
    input  logic                          i_clk,
    input  ddh_pkg::t_pipe_en             i_en,
    input  logic [ddh_pkg::YEAR_W-1:0]    i_year,
    input  logic [ddh_pkg::MONTH_W-1:0]   i_month,
    input  logic [ddh_pkg::DAY_W-1:0]     i_day,
    output logic [ddh_pkg::YEAR_W-1:0]    o_year,
    output logic [ddh_pkg::MONTH_W-1:0]   o_month,
    output logic [ddh_pkg::DAY_W-1:0]     o_day,
    output logic [ddh_pkg::QUOT_W-1:0]    o_quot,
    output logic [ddh_pkg::REM_W-1:0]     o_rem
);

    logic [ddh_pkg::PROD_W-1:0]  w_prod;
    logic [ddh_pkg::YEAR_W-1:0]  r_year1;
    logic [ddh_pkg::MONTH_W-1:0] r_month1;
    logic [ddh_pkg::DAY_W-1:0]   r_day1;
    logic [ddh_pkg::QUOT_W-1:0]  r_quot1;

    logic [ddh_pkg::YEAR_W-1:0]  w_rem_full;
    logic [ddh_pkg::REM0_W-1:0]  w_rem0;
    logic [ddh_pkg::QUOT_W-1:0]  n_quot2;
    logic [ddh_pkg::REM_W-1:0]   n_rem2;

    logic [ddh_pkg::YEAR_W-1:0]  r_year2;
    logic [ddh_pkg::MONTH_W-1:0] r_month2;
    logic [ddh_pkg::DAY_W-1:0]   r_day2;
    logic [ddh_pkg::QUOT_W-1:0]  r_quot2;
    logic [ddh_pkg::REM_W-1:0]   r_rem2;

    assign w_prod = ddh_pkg::PROD_W'(i_year) * ddh_pkg::PROD_W'(ddh_pkg::RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_year1  <= i_year;
            r_month1 <= i_month;
            r_day1   <= i_day;
            r_quot1  <= w_prod[ddh_pkg::PROD_W-1:ddh_pkg::RECIP_SHIFT];
        end
    end

    // estimate is low by at most one
    always_comb begin
        w_rem_full = r_year1 - ddh_pkg::YEAR_W'(r_quot1) * ddh_pkg::YEAR_W'(ddh_pkg::CENTURY);
        w_rem0     = w_rem_full[ddh_pkg::REM0_W-1:0];
        if (w_rem0 >= ddh_pkg::REM0_W'(ddh_pkg::CENTURY)) begin
            n_quot2 = r_quot1 + ddh_pkg::QUOT_W'(1);
            n_rem2  = ddh_pkg::REM_W'(w_rem0 - ddh_pkg::REM0_W'(ddh_pkg::CENTURY));
        end else begin
            n_quot2 = r_quot1;
            n_rem2  = w_rem0[ddh_pkg::REM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_year2  <= r_year1;
            r_month2 <= r_month1;
            r_day2   <= r_day1;
            r_quot2  <= n_quot2;
            r_rem2   <= n_rem2;
        end
    end

    assign o_year  = r_year2;
    assign o_month = r_month2;
    assign o_day   = r_day2;
    assign o_quot  = r_quot2;
    assign o_rem   = r_rem2;

endmodule

/* hw/rtl/ddh_day_index.sv */
// ----------------------------------------------------------------------------
// ddh_day_index
// stage three: day count since year zero of the proleptic calendar
// ----------------------------------------------------------------------------
module ddh_day_index (
    input  logic                          i_clk,
    input  ddh_pkg::t_pipe_en             i_en,
    input  logic [ddh_pkg::YEAR_W-1:0]    i_year,
    input  logic [ddh_pkg::MONTH_W-1:0]   i_month,
    input  logic [ddh_pkg::DAY_W-1:0]     i_day,
    input  logic [ddh_pkg::QUOT_W-1:0]    i_quot,
    input  logic [ddh_pkg::REM_W-1:0]     i_rem,
    output logic [ddh_pkg::DIDX_W-1:0]    o_day_index
);

    logic                        w_cent_nz;
    logic                        w_quad_nz;
    logic                        w_leap;
    logic                        w_leap_add;
    logic [ddh_pkg::SUM_W-1:0]   w_sum;
    logic [ddh_pkg::DIDX_W-1:0]  r_day_index;

    always_comb begin
        w_cent_nz  = (i_rem != '0);
        w_quad_nz  = w_cent_nz || (i_quot[1:0] != 2'd0);
        w_leap     = ((i_year[1:0] == 2'd0) && w_cent_nz) || (!w_cent_nz && (i_quot[1:0] == 2'd0));
        w_leap_add = w_leap && (i_month > ddh_pkg::MONTH_W'(ddh_pkg::MONTH_FEB));
        w_sum = ddh_pkg::SUM_W'(i_year) * ddh_pkg::SUM_W'(ddh_pkg::DAYS_PER_YEAR)
              + ((ddh_pkg::SUM_W'(i_year) + ddh_pkg::SUM_W'(3)) >> 2)
              - ddh_pkg::SUM_W'(i_quot)
              - ddh_pkg::SUM_W'(w_cent_nz)
              + ddh_pkg::SUM_W'(i_quot >> 2)
              + ddh_pkg::SUM_W'(w_quad_nz)
              + ddh_pkg::SUM_W'(ddh_pkg::days_before_month(i_month))
              + ddh_pkg::SUM_W'(w_leap_add)
              + ddh_pkg::SUM_W'(i_day);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_day_index <= w_sum[ddh_pkg::DIDX_W-1:0];
        end
    end

    assign o_day_index = r_day_index;

endmodule

/* hw/rtl/date_difference_hours_core.sv */
// ----------------------------------------------------------------------------
// date_difference_hours_core
// hours between two calendar date-times, four stage pipeline
// ----------------------------------------------------------------------------
// One transfer is taken every cycle when the output side does not stall, and
// its result is held in the stage four register. Stage one forms the year
// over 100 by a reciprocal multiply, stage two corrects it, stage three sums
// the day index of both dates, stage four scales the day difference to hours
// and saturates. Each stage has its own enable, so a stall holds only the
// stages that are full and empty slots close up.
// ----------------------------------------------------------------------------
`include "date_difference_hours_core_assert.svh"

module date_difference_hours_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [ddh_pkg::YEAR_W-1:0]        i_start_year,
    input  logic [ddh_pkg::MONTH_W-1:0]       i_start_month,
    input  logic [ddh_pkg::DAY_W-1:0]         i_start_day,
    input  logic [ddh_pkg::HOUR_W-1:0]        i_start_hour,
    input  logic [ddh_pkg::MIN_W-1:0]         i_start_minute,
    input  logic [ddh_pkg::SEC_W-1:0]         i_start_second,
    input  logic [ddh_pkg::YEAR_W-1:0]        i_end_year,
    input  logic [ddh_pkg::MONTH_W-1:0]       i_end_month,
    input  logic [ddh_pkg::DAY_W-1:0]         i_end_day,
    input  logic [ddh_pkg::HOUR_W-1:0]        i_end_hour,
    input  logic [ddh_pkg::MIN_W-1:0]         i_end_minute,
    input  logic [ddh_pkg::SEC_W-1:0]         i_end_second,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [ddh_pkg::HOURS_W-1:0] o_hours,
    output logic                              o_order_error
);

    ddh_pkg::t_pipe_en w_en;
    logic              w_en4;

    logic r_v1, r_v2, r_v3, r_v4;

    logic                              w_err;
    logic signed [ddh_pkg::HD_W-1:0]   w_hd;
    logic signed [ddh_pkg::MS_W-1:0]   w_min_diff;
    logic signed [ddh_pkg::MS_W-1:0]   w_sec_diff;
    logic signed [ddh_pkg::MS_W-1:0]   w_ms;

    logic                              r_err1, r_err2, r_err3;
    logic                              r_ge1, r_ge2, r_ge3;
    logic signed [ddh_pkg::HD_W-1:0]   r_hd1, r_hd2, r_hd3;

    logic [ddh_pkg::YEAR_W-1:0]  w_s_year,  w_e_year;
    logic [ddh_pkg::MONTH_W-1:0] w_s_month, w_e_month;
    logic [ddh_pkg::DAY_W-1:0]   w_s_day,   w_e_day;
    logic [ddh_pkg::QUOT_W-1:0]  w_s_quot,  w_e_quot;
    logic [ddh_pkg::REM_W-1:0]   w_s_rem,   w_e_rem;
    logic [ddh_pkg::DIDX_W-1:0]  w_s_didx,  w_e_didx;

    logic signed [ddh_pkg::SUM_W-1:0]  w_diff;
    logic signed [ddh_pkg::WIDE_W-1:0] w_diff_w;
    logic signed [ddh_pkg::WIDE_W-1:0] w_wide;
    logic signed [ddh_pkg::HOURS_W-1:0] n_hours;

    logic signed [ddh_pkg::HOURS_W-1:0] r_hours;
    logic                               r_err4;

    // per-stage enables, a stage moves when empty or when the next one moves
    always_comb begin
        w_en4   = !r_v4 || !i_stall;
        w_en.s3 = !r_v3 || w_en4;
        w_en.s2 = !r_v2 || w_en.s3;
        w_en.s1 = !r_v1 || w_en.s2;
    end

    assign o_stall = !w_en.s1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en.s1) begin
                r_v1 <= i_valid;
            end
            if (w_en.s2) begin
                r_v2 <= r_v1;
            end
            if (w_en.s3) begin
                r_v3 <= r_v2;
            end
            if (w_en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // order check and time of day terms
    always_comb begin
        w_err = (i_start_year > i_end_year)
             || ((i_start_year == i_end_year) && (i_start_month > i_end_month));
        w_hd  = $signed(ddh_pkg::HD_W'(i_end_hour)) - $signed(ddh_pkg::HD_W'(i_start_hour));
        w_min_diff = $signed(ddh_pkg::MS_W'(i_end_minute))
                   - $signed(ddh_pkg::MS_W'(i_start_minute));
        w_sec_diff = $signed(ddh_pkg::MS_W'(i_end_second))
                   - $signed(ddh_pkg::MS_W'(i_start_second));
        w_ms = w_min_diff * $signed(ddh_pkg::MS_W'(ddh_pkg::SEC_PER_MIN)) + w_sec_diff;
    end

    always_ff @(posedge i_clk) begin
        if (w_en.s1) begin
            r_err1 <= w_err;
            r_hd1  <= w_hd;
            r_ge1  <= !w_ms[ddh_pkg::MS_W-1];
        end
        if (w_en.s2) begin
            r_err2 <= r_err1;
            r_hd2  <= r_hd1;
            r_ge2  <= r_ge1;
        end
        if (w_en.s3) begin
            r_err3 <= r_err2;
            r_hd3  <= r_hd2;
            r_ge3  <= r_ge2;
        end
    end

    ddh_date_split u_split_start (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (i_start_year),
        .i_month (i_start_month),
        .i_day   (i_start_day),
        .o_year  (w_s_year),
        .o_month (w_s_month),
        .o_day   (w_s_day),
        .o_quot  (w_s_quot),
        .o_rem   (w_s_rem)
    );

    ddh_date_split u_split_end (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_year  (i_end_year),
        .i_month (i_end_month),
        .i_day   (i_end_day),
        .o_year  (w_e_year),
        .o_month (w_e_month),
        .o_day   (w_e_day),
        .o_quot  (w_e_quot),
        .o_rem   (w_e_rem)
    );

    ddh_day_index u_didx_start (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_year      (w_s_year),
        .i_month     (w_s_month),
        .i_day       (w_s_day),
        .i_quot      (w_s_quot),
        .i_rem       (w_s_rem),
        .o_day_index (w_s_didx)
    );

    ddh_day_index u_didx_end (
        .i_clk       (i_clk),
        .i_en        (w_en),
        .i_year      (w_e_year),
        .i_month     (w_e_month),
        .i_day       (w_e_day),
        .i_quot      (w_e_quot),
        .i_rem       (w_e_rem),
        .o_day_index (w_e_didx)
    );

    // day difference times 24 plus hour terms, then saturate; an order error gives zero
    always_comb begin
        w_diff   = $signed(ddh_pkg::SUM_W'(w_e_didx)) - $signed(ddh_pkg::SUM_W'(w_s_didx));
        w_diff_w = ddh_pkg::WIDE_W'(w_diff);
        w_wide   = (w_diff_w <<< 4) + (w_diff_w <<< 3)
                 + ddh_pkg::WIDE_W'(r_hd3)
                 + $signed(ddh_pkg::WIDE_W'(r_ge3));
        if (r_err3) begin
            n_hours = '0;
        end else if (w_wide > ddh_pkg::WIDE_W'(ddh_pkg::HOURS_MAX)) begin
            n_hours = ddh_pkg::HOURS_W'(ddh_pkg::HOURS_MAX);
        end else if (w_wide < ddh_pkg::WIDE_W'(ddh_pkg::HOURS_MIN)) begin
            n_hours = ddh_pkg::HOURS_W'(ddh_pkg::HOURS_MIN);
        end else begin
            n_hours = w_wide[ddh_pkg::HOURS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_hours <= n_hours;
            r_err4  <= r_err3;
        end
    end

    assign o_valid       = r_v4;
    assign o_hours       = r_hours;
    assign o_order_error = r_err4;

    `DDH_ASSERT(a_no_stall_when_out_empty, i_clk, i_rst_n, !r_v4 |-> !o_stall)
    `DDH_ASSERT(a_accept_fills_stage1, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_v1)
    `DDH_ASSERT_MSG(a_error_gives_zero, i_clk, i_rst_n, (o_valid && o_order_error) |-> (o_hours == '0), "flagged result with nonzero hours")

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the date difference core against a cycle free hours predictor
// ----------------------------------------------------------------------------
// Start and end date-times are driven through the valid/stall input channel.
// Every input transfer is turned into an expected hour count and order flag.
// Every output transfer is compared with the oldest expectation. A short
// directed set covers field extremes, leap and century years, year
// crossings, out of range fields and saturation. Random pairs follow. They
// are mostly well formed and ordered, with some raw bit patterns mixed in.
// Sender gaps and receiver stalls vary from phase to phase. One phase holds
// the output side off long enough to back the pipeline up into its input.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [ddh_pkg::YEAR_W-1:0]  year;
    logic [ddh_pkg::MONTH_W-1:0] month;
    logic [ddh_pkg::DAY_W-1:0]   day;
    logic [ddh_pkg::HOUR_W-1:0]  hour;
    logic [ddh_pkg::MIN_W-1:0]   minute;
    logic [ddh_pkg::SEC_W-1:0]   second;
} t_date;

typedef struct {
    logic signed [ddh_pkg::HOURS_W-1:0] hours;
    logic                               order_error;
} t_hours_result;

function automatic bit is_leap(int y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
endfunction

function automatic t_date dt(int y, int m, int d, int h, int mi, int s);
    t_date r;
    r.year   = y[ddh_pkg::YEAR_W-1:0];
    r.month  = m[ddh_pkg::MONTH_W-1:0];
    r.day    = d[ddh_pkg::DAY_W-1:0];
    r.hour   = h[ddh_pkg::HOUR_W-1:0];
    r.minute = mi[ddh_pkg::MIN_W-1:0];
    r.second = s[ddh_pkg::SEC_W-1:0];
    return r;
endfunction

class hours_scoreboard;
    t_hours_result pending_hours[$];
    int            mismatches;

    function new();
        mismatches = 0;
    endfunction

    function int day_number(t_date t);
        int yr;
        int mo;
        int days;
        yr = int'(t.year);
        mo = (t.month == 0) ? 1 : ((t.month > 12) ? 12 : int'(t.month));
        days = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400 + int'(t.day);
        case (mo)
            2:       days += 31;
            3:       days += 59;
            4:       days += 90;
            5:       days += 120;
            6:       days += 151;
            7:       days += 181;
            8:       days += 212;
            9:       days += 243;
            10:      days += 273;
            11:      days += 304;
            12:      days += 334;
            default: days += 0;
        endcase
        if (mo > 2 && is_leap(yr)) begin
            days += 1;
        end
        return days;
    endfunction

    function t_hours_result predict_hours(t_date s, t_date e);
        t_hours_result r;
        longint        h;
        int            tie;
        r.order_error = (s.year > e.year) || (s.year == e.year && s.month > e.month);
        if (r.order_error) begin
            r.hours = '0;
        end else begin
            h = longint'(day_number(e) - day_number(s)) * 24;
            h += int'(e.hour) - int'(s.hour);
            tie = (int'(e.minute) - int'(s.minute)) * 60 + int'(e.second) - int'(s.second);
            if (tie >= 0) begin
                h += 1;
            end
            if (h > ddh_pkg::HOURS_MAX) begin
                h = ddh_pkg::HOURS_MAX;
            end
            if (h < ddh_pkg::HOURS_MIN) begin
                h = ddh_pkg::HOURS_MIN;
            end
            r.hours = h[ddh_pkg::HOURS_W-1:0];
        end
        return r;
    endfunction

    function void note_dates(t_date s, t_date e);
        pending_hours.push_back(predict_hours(s, e));
    endfunction

    function void flag(string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch: %s", what);
        end
    endfunction

    function void check_hours(logic signed [ddh_pkg::HOURS_W-1:0] hours, logic order_error);
        t_hours_result x;
        if (pending_hours.size() == 0) begin
            flag($sformatf("unexpected result hours %0d order_error %0b", hours, order_error));
        end else begin
            x = pending_hours.pop_front();
            if (hours !== x.hours || order_error !== x.order_error) begin
                flag($sformatf("hours exp %0d act %0d, order_error exp %0b act %0b",
                               x.hours, hours, x.order_error, order_error));
            end
        end
    endfunction

    function int outstanding();
        return pending_hours.size();
    endfunction
endclass

module testbench;

    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_valid;
    logic                               o_stall;
    t_date                              drv_start;
    t_date                              drv_end;
    logic                               o_valid;
    logic                               i_stall;
    logic signed [ddh_pkg::HOURS_W-1:0] o_hours;
    logic                               o_order_error;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int idle_run       = 0;

    hours_scoreboard sb = new();

    date_difference_hours_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_start_year   (drv_start.year),
        .i_start_month  (drv_start.month),
        .i_start_day    (drv_start.day),
        .i_start_hour   (drv_start.hour),
        .i_start_minute (drv_start.minute),
        .i_start_second (drv_start.second),
        .i_end_year     (drv_end.year),
        .i_end_month    (drv_end.month),
        .i_end_day      (drv_end.day),
        .i_end_hour     (drv_end.hour),
        .i_end_minute   (drv_end.minute),
        .i_end_second   (drv_end.second),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_hours        (o_hours),
        .o_order_error  (o_order_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // input and output transfer monitors
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            sb.note_dates(drv_start, drv_end);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_hours(o_hours, o_order_error);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_run <= 0;
        end else begin
            idle_run <= idle_run + 1;
        end
        if (idle_run >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when requested
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request != hold_served) begin
                hold_served = hold_request;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    function automatic int month_days(int y, int m);
        case (m)
            2:             return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    function automatic void random_pair(output t_date s, output t_date e);
        int kind;
        int sy;
        int ey;
        int sm;
        int em;
        int smi;
        int ss;
        kind = $urandom_range(0, 9);
        if (kind == 9) begin
            s = dt($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
            e = dt($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31),
                   $urandom_range(0, 31), $urandom_range(0, 63), $urandom_range(0, 63));
            return;
        end
        sy = $urandom_range(1900, 2411);
        case ($urandom_range(0, 3))
            0:       ey = sy;
            1:       ey = (sy < 2411) ? sy + $urandom_range(0, 1) : sy;
            2:       ey = (sy + 20 > 2411) ? 2411 : sy + $urandom_range(0, 20);
            default: ey = $urandom_range(sy, 2411);
        endcase
        if (kind == 8) begin
            ey = $urandom_range(1900, 2411);
        end
        sm = $urandom_range(1, 12);
        if (kind == 6 || kind == 7) begin
            ey = sy;
            em = sm;
        end else if (ey == sy && kind < 8) begin
            em = $urandom_range(sm, 12);
        end else begin
            em = $urandom_range(1, 12);
        end
        smi = $urandom_range(0, 59);
        ss  = $urandom_range(0, 60);
        s = dt(sy, sm, $urandom_range(1, month_days(sy, sm)), $urandom_range(0, 23), smi, ss);
        e = dt(ey, em, $urandom_range(1, month_days(ey, em)), $urandom_range(0, 23),
               $urandom_range(0, 59), $urandom_range(0, 60));
        if ($urandom_range(0, 3) == 0) begin
            e.minute = s.minute;
            if ($urandom_range(0, 1) == 0) begin
                e.second = s.second;
            end
        end
    endfunction

    task automatic send_pair(t_date s, t_date e);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        drv_start <= s;
        drv_end   <= e;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.outstanding() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(int count, int send_pct, int recv_pct);
        t_date s;
        t_date e;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) begin
            random_pair(s, e);
            send_pair(s, e);
        end
        drain();
    endtask

    initial begin
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        drv_start <= '0;
        drv_end   <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs
        send_pair(dt(1900, 1, 1, 0, 0, 0), dt(1900, 1, 1, 0, 0, 0));
        send_pair(dt(1900, 1, 1, 0, 0, 0), dt(2411, 12, 31, 23, 59, 60));
        send_pair(dt(2000, 2, 28, 12, 0, 0), dt(2000, 3, 1, 12, 0, 0));
        send_pair(dt(1900, 2, 28, 12, 0, 0), dt(1900, 3, 1, 12, 0, 0));
        send_pair(dt(2004, 2, 29, 6, 15, 0), dt(2004, 3, 1, 6, 15, 0));
        send_pair(dt(2023, 12, 31, 23, 0, 0), dt(2024, 1, 1, 1, 0, 0));
        send_pair(dt(2001, 5, 5, 5, 5, 5), dt(2000, 5, 5, 5, 5, 5));
        send_pair(dt(2010, 7, 1, 0, 0, 0), dt(2010, 6, 30, 0, 0, 0));
        send_pair(dt(2010, 5, 20, 8, 0, 0), dt(2010, 5, 3, 8, 0, 0));
        send_pair(dt(2015, 3, 3, 10, 30, 30), dt(2015, 3, 4, 10, 30, 29));
        send_pair(dt(2016, 12, 31, 23, 59, 60), dt(2017, 1, 1, 0, 0, 59));
        send_pair(dt(2020, 0, 10, 1, 2, 3), dt(2020, 15, 10, 1, 2, 3));
        send_pair(dt(2020, 13, 5, 0, 0, 0), dt(2020, 14, 5, 0, 0, 0));
        send_pair(dt(2021, 2, 0, 0, 0, 0), dt(2021, 2, 31, 0, 0, 0));
        send_pair(dt(2030, 6, 6, 31, 63, 63), dt(2030, 6, 7, 0, 0, 0));
        send_pair(dt(0, 1, 1, 0, 0, 0), dt(4095, 12, 31, 23, 59, 59));
        send_pair(dt(4095, 15, 31, 31, 63, 63), dt(4095, 15, 31, 31, 63, 63));
        send_pair(dt(0, 0, 0, 0, 0, 0), dt(0, 0, 0, 0, 0, 0));
        send_pair(dt(4095, 15, 31, 31, 63, 63), dt(0, 0, 0, 0, 0, 0));
        send_pair(dt(2400, 2, 29, 0, 0, 0), dt(2411, 3, 1, 0, 0, 0));
        send_pair(dt(2410, 12, 31, 12, 0, 0), dt(2411, 1, 1, 12, 0, 0));
        send_pair(dt(1999, 12, 31, 23, 59, 59), dt(1999, 12, 1, 0, 0, 0));
        drain();

        run_phase(400, 0, 0);
        run_phase(380, 59, 0);
        run_phase(380, 0, 59);
        run_phase(380, 35, 35);

        // long receiver hold-off while the sender keeps offering
        recv_stall_pct = 0;
        hold_request <= hold_request + 1;
        run_phase(200, 0, 0);

        run_phase(190, 35, 35);

        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
